>>> hw/rtl/shader_table_directory_validator_top_defines.svh
// Assertion macros shared by the shader table directory validator RTL.
// Simulation builds get concurrent assertions; synthesis builds get nothing.
`ifndef SHADER_TABLE_DIRECTORY_VALIDATOR_TOP_DEFINES_SVH
`define SHADER_TABLE_DIRECTORY_VALIDATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define STDV_ASSERT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("stdv assertion failed");
// next-cycle implication
`define STDV_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("stdv assertion failed");
`else
`define STDV_ASSERT(lbl, clk, rstn, ante, cons)
`define STDV_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif

`endif

>>> hw/rtl/stdv_pkg.sv
// Shared types and constants for the shader table directory validator.
// No dependencies; used by stdv_ctrl, stdv_datapath and the top level.
`default_nettype none

package stdv_pkg;

    localparam int STORE_WORDS = 512;
    localparam int ADDR_W      = (STORE_WORDS > 2) ? $clog2(STORE_WORDS) : 1;
    localparam int WCNT_W      = $clog2(STORE_WORDS + 1);
    localparam int LEN_W       = $clog2(STORE_WORDS * 8 + 1);

    localparam int HEADER_BYTES   = 8;
    localparam int MIN_BLOB_BYTES = 20;
    localparam int ALIGN_BITS     = 3;   // 8-byte alignment
    localparam int GRAIN_BITS     = 2;   // sizes in multiples of 4
    localparam logic [31:0] MAGIC_WORD = 32'h0723_0203;

    localparam int WORD_W   = 64;
    localparam int VB_W     = 4;
    localparam int BASE_W   = 3;
    localparam int STAT_W   = 4;
    localparam int OFF_W    = 13;
    localparam int COUNT_W  = 8;
    localparam int S_DATA_W = 72;
    localparam int M_DATA_W = 32;

    typedef enum logic [3:0] {
        STAT_OK              = 4'd0,
        STAT_TOO_SMALL       = 4'd1,
        STAT_BASE_MISALIGNED = 4'd2,
        STAT_RSV_NONZERO     = 4'd3,
        STAT_SIZE_MISMATCH   = 4'd4,
        STAT_BLOB_MISALIGNED = 4'd5,
        STAT_OUT_OF_BOUNDS   = 4'd6,
        STAT_BAD_SIZE        = 4'd7,
        STAT_BAD_MAGIC       = 4'd8,
        STAT_TOO_LARGE       = 4'd9
    } status_t;

    typedef enum logic [1:0] {
        RD_HDR,
        RD_BOFF,
        RD_BSIZE,
        RD_MAGIC
    } rd_sel_t;

    typedef enum logic [1:0] {
        OFF_ZERO,
        OFF_RSV,
        OFF_ENTRY,
        OFF_BLOB
    } off_sel_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_PRE,
        ST_HDR,
        ST_EOFF,
        ST_ESIZE,
        ST_EMAGIC,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic     load;
        rd_sel_t  rd_sel;
        logic     capture_hdr;
        logic     capture_boff;
        logic     idx_inc;
        logic     push;
        status_t  code;
        off_sel_t off_sel;
    } cmd_t;

    typedef struct packed {
        logic cap;
        logic len_short;
        logic base_mis;
        logic rsv_nz;
        logic dir_bad;
        logic n_zero;
        logic blob_mis;
        logic boff_oob;
        logic size_oob;
        logic bad_size;
        logic bad_magic;
        logic last_entry;
    } flags_t;

endpackage

`default_nettype wire

>>> hw/rtl/shader_table_directory_validator_top.sv
// Shader table directory validator, top level: stream ports, sequencer and
// datapath. Depends on stdv_pkg, stdv_ctrl and stdv_datapath.
//
// Usage:
//   The slave channel carries a table image, one little-endian 64-bit word
//   per request, first byte in bits 7:0. s_tlast marks the final word; its
//   valid-byte count gives the length of that word. Base address low bits
//   are sampled with the first word of a table.
//   Words are taken one per cycle while loading. After the last word the
//   block walks the header and directory out of its word store and issues
//   one verdict request on the master channel.
//   The verdict comes from the length/base/capacity checks, else from the
//   header checks or an empty directory, else from the walk over the N
//   entries: each entry costs three reads of the store's single read port
//   (offset, size, magic word).
//   s_tready is low from the last word until the verdict enters the output
//   register. While the receiver stalls, the verdict is held and the next
//   table's words are still taken; its verdict waits until the first leaves.
//   Reset (aresetn low, synchronous) empties the load counters and the
//   output register; store contents are left as they are.
`default_nettype none

module shader_table_directory_validator_top (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // [63:0] table_word, [67:64] valid_bytes, [70:68] base_low_bits, [71] zero
    input  wire logic [71:0] s_tdata,
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // [3:0] status, [16:4] fail_offset, [24:17] entry_count, [31:25] zero
    output logic [31:0]      m_tdata
);

    stdv_pkg::cmd_t   cmd;
    stdv_pkg::flags_t flags;

    stdv_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .flags    (flags),
        .cmd      (cmd)
    );

    stdv_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .cmd     (cmd),
        .flags   (flags),
        .m_tdata (m_tdata)
    );

endmodule

`default_nettype wire

>>> hw/rtl/stdv_ctrl.sv
// Check sequencer for the shader table directory validator.
// Depends on stdv_pkg; drives stdv_datapath through cmd_t, reads flags_t.
`default_nettype none
`include "shader_table_directory_validator_top_defines.svh"

module stdv_ctrl (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_tvalid,
    input  wire logic            s_tlast,
    output logic                 s_tready,
    output logic                 m_tvalid,
    input  wire logic            m_tready,
    input  wire stdv_pkg::flags_t flags,
    output stdv_pkg::cmd_t       cmd
);

    stdv_pkg::state_t   state_reg, state_next;
    stdv_pkg::status_t  code_reg, code_next;
    stdv_pkg::off_sel_t off_reg, off_next;
    logic               m_tvalid_reg, m_tvalid_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= stdv_pkg::ST_LOAD;
            code_reg     <= stdv_pkg::STAT_OK;
            off_reg      <= stdv_pkg::OFF_ZERO;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            code_reg     <= code_next;
            off_reg      <= off_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    // next state and verdict capture
    always_comb begin
        state_next = state_reg;
        code_next  = code_reg;
        off_next   = off_reg;
        unique case (state_reg)
            stdv_pkg::ST_LOAD: begin
                if (s_tvalid && s_tlast) begin
                    state_next = stdv_pkg::ST_PRE;
                end
            end
            stdv_pkg::ST_PRE: begin
                state_next = stdv_pkg::ST_DONE;
                off_next   = stdv_pkg::OFF_ZERO;
                priority if (flags.cap) begin
                    code_next = stdv_pkg::STAT_TOO_LARGE;
                end else if (flags.len_short) begin
                    code_next = stdv_pkg::STAT_TOO_SMALL;
                end else if (flags.base_mis) begin
                    code_next = stdv_pkg::STAT_BASE_MISALIGNED;
                end else begin
                    state_next = stdv_pkg::ST_HDR;
                end
            end
            stdv_pkg::ST_HDR: begin
                state_next = stdv_pkg::ST_DONE;
                off_next   = stdv_pkg::OFF_ZERO;
                priority if (flags.rsv_nz) begin
                    code_next = stdv_pkg::STAT_RSV_NONZERO;
                    off_next  = stdv_pkg::OFF_RSV;
                end else if (flags.dir_bad) begin
                    code_next = stdv_pkg::STAT_SIZE_MISMATCH;
                end else if (flags.n_zero) begin
                    code_next = stdv_pkg::STAT_OK;
                end else begin
                    state_next = stdv_pkg::ST_EOFF;
                end
            end
            stdv_pkg::ST_EOFF: begin
                state_next = stdv_pkg::ST_DONE;
                off_next   = stdv_pkg::OFF_ENTRY;
                priority if (flags.blob_mis) begin
                    code_next = stdv_pkg::STAT_BLOB_MISALIGNED;
                end else if (flags.boff_oob) begin
                    code_next = stdv_pkg::STAT_OUT_OF_BOUNDS;
                end else begin
                    state_next = stdv_pkg::ST_ESIZE;
                end
            end
            stdv_pkg::ST_ESIZE: begin
                state_next = stdv_pkg::ST_DONE;
                off_next   = stdv_pkg::OFF_ENTRY;
                priority if (flags.size_oob) begin
                    code_next = stdv_pkg::STAT_OUT_OF_BOUNDS;
                end else if (flags.bad_size) begin
                    code_next = stdv_pkg::STAT_BAD_SIZE;
                end else begin
                    state_next = stdv_pkg::ST_EMAGIC;
                end
            end
            stdv_pkg::ST_EMAGIC: begin
                priority if (flags.bad_magic) begin
                    state_next = stdv_pkg::ST_DONE;
                    code_next  = stdv_pkg::STAT_BAD_MAGIC;
                    off_next   = stdv_pkg::OFF_BLOB;
                end else if (flags.last_entry) begin
                    state_next = stdv_pkg::ST_DONE;
                    code_next  = stdv_pkg::STAT_OK;
                    off_next   = stdv_pkg::OFF_ZERO;
                end else begin
                    state_next = stdv_pkg::ST_EOFF;
                end
            end
            stdv_pkg::ST_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    state_next = stdv_pkg::ST_LOAD;
                end
            end
            default: begin
                state_next = stdv_pkg::ST_LOAD;
            end
        endcase
    end

    // outputs
    always_comb begin
        s_tready         = (state_reg == stdv_pkg::ST_LOAD);
        cmd.load         = s_tvalid && s_tready;
        cmd.capture_hdr  = (state_reg == stdv_pkg::ST_HDR);
        cmd.capture_boff = (state_reg == stdv_pkg::ST_EOFF);
        cmd.idx_inc      = (state_reg == stdv_pkg::ST_EMAGIC) && !flags.bad_magic
                           && !flags.last_entry;
        cmd.push         = (state_reg == stdv_pkg::ST_DONE) && (!m_tvalid_reg || m_tready);
        cmd.code         = code_reg;
        cmd.off_sel      = off_reg;
        unique case (state_reg)
            stdv_pkg::ST_HDR:    cmd.rd_sel = stdv_pkg::RD_BOFF;
            stdv_pkg::ST_EOFF:   cmd.rd_sel = stdv_pkg::RD_BSIZE;
            stdv_pkg::ST_ESIZE:  cmd.rd_sel = stdv_pkg::RD_MAGIC;
            stdv_pkg::ST_EMAGIC: cmd.rd_sel = stdv_pkg::RD_BOFF;
            default:             cmd.rd_sel = stdv_pkg::RD_HDR;
        endcase
    end

    always_comb begin
        if (cmd.push) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    `STDV_ASSERT(a_push_room, aclk, aresetn, cmd.push, !m_tvalid_reg || m_tready)
    `STDV_ASSERT_NEXT(a_push_shows, aclk, aresetn, cmd.push, m_tvalid_reg)
    `STDV_ASSERT(a_leave_on_last, aclk, aresetn, state_reg == stdv_pkg::ST_LOAD && state_next != stdv_pkg::ST_LOAD, s_tvalid && s_tready && s_tlast)

endmodule

`default_nettype wire

>>> hw/rtl/stdv_datapath.sv
// Datapath of the shader table directory validator: word store, load
// counters, per-check compares and the result register. Depends on stdv_pkg.
`default_nettype none
`include "shader_table_directory_validator_top_defines.svh"

module stdv_datapath (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic [stdv_pkg::S_DATA_W-1:0] s_tdata,
    input  wire logic                          s_tlast,
    input  wire stdv_pkg::cmd_t                cmd,
    output stdv_pkg::flags_t                   flags,
    output logic [stdv_pkg::M_DATA_W-1:0]      m_tdata
);

    localparam int AW = stdv_pkg::ADDR_W;
    localparam int LW = stdv_pkg::LEN_W;

    logic [stdv_pkg::WORD_W-1:0] mem [stdv_pkg::STORE_WORDS];
    logic [stdv_pkg::WORD_W-1:0] rdata_reg;
    logic [AW-1:0]               rd_addr;

    logic [stdv_pkg::WCNT_W-1:0] words_reg;
    logic [LW-1:0]               len_reg;
    logic                        mis_reg;
    logic                        cap_reg;
    logic [AW-1:0]               idx_reg, idx_next;
    logic [AW-1:0]               n_reg;
    logic [LW-1:0]               dir_end_reg;
    logic [stdv_pkg::WORD_W-1:0] boff_reg;
    logic [LW-1:0]               rem_reg;

    logic [stdv_pkg::STAT_W-1:0]  m_status_reg;
    logic [stdv_pkg::OFF_W-1:0]   m_off_reg;
    logic [stdv_pkg::COUNT_W-1:0] m_count_reg;

    logic [stdv_pkg::WORD_W-1:0] in_word;
    logic [stdv_pkg::VB_W-1:0]   in_vb;
    logic [stdv_pkg::BASE_W-1:0] in_base;
    logic                        full;
    logic [LW-1:0]               len_add;
    logic [AW:0]                 boff_word;
    logic [AW:0]                 bsize_word;
    logic [36:0]                 dir_end_full;
    logic [LW-1:0]               rem_next;
    logic [stdv_pkg::OFF_W-1:0]  off_mux;

    assign in_word = s_tdata[63:0];
    assign in_vb   = s_tdata[67:64];
    assign in_base = s_tdata[70:68];

    assign full = (words_reg == stdv_pkg::WCNT_W'(stdv_pkg::STORE_WORDS));

    // only the last word may be short; more than 8 saturates
    always_comb begin
        if (!s_tlast) begin
            len_add = LW'(8);
        end else if (in_vb > stdv_pkg::VB_W'(8)) begin
            len_add = LW'(8);
        end else begin
            len_add = LW'(in_vb);
        end
    end

    assign idx_next = cmd.idx_inc ? idx_reg + AW'(1) : idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            words_reg <= '0;
            len_reg   <= '0;
            mis_reg   <= 1'b0;
            cap_reg   <= 1'b0;
            idx_reg   <= '0;
        end else if (cmd.push) begin
            words_reg <= '0;
            len_reg   <= '0;
            mis_reg   <= 1'b0;
            cap_reg   <= 1'b0;
            idx_reg   <= '0;
        end else begin
            idx_reg <= idx_next;
            if (cmd.load) begin
                if (words_reg == '0) begin
                    mis_reg <= (in_base != '0);
                end
                if (full) begin
                    cap_reg <= 1'b1;
                end else begin
                    words_reg <= words_reg + stdv_pkg::WCNT_W'(1);
                    len_reg   <= len_reg + len_add;
                end
            end
        end
    end

    // entry i sits in words 2i+1 (blob offset) and 2i+2 (blob size)
    assign boff_word  = {idx_next, 1'b1};
    assign bsize_word = {idx_reg, 1'b0} + (AW + 1)'(2);

    always_comb begin
        unique case (cmd.rd_sel)
            stdv_pkg::RD_HDR:   rd_addr = '0;
            stdv_pkg::RD_BOFF:  rd_addr = boff_word[AW-1:0];
            stdv_pkg::RD_BSIZE: rd_addr = bsize_word[AW-1:0];
            stdv_pkg::RD_MAGIC: rd_addr = boff_reg[AW+2:3];
            default:            rd_addr = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.load && !full) begin
            mem[words_reg[AW-1:0]] <= in_word;
        end
        rdata_reg <= mem[rd_addr];
    end

    assign dir_end_full = (37'(rdata_reg[31:0]) << 4) + 37'(stdv_pkg::HEADER_BYTES);
    assign rem_next     = len_reg - rdata_reg[LW-1:0];

    always_ff @(posedge aclk) begin
        if (cmd.capture_hdr) begin
            n_reg       <= rdata_reg[AW-1:0];
            dir_end_reg <= dir_end_full[LW-1:0];
        end
        if (cmd.capture_boff) begin
            boff_reg <= rdata_reg;
            rem_reg  <= rem_next;
        end
    end

    always_comb begin
        flags.cap        = cap_reg;
        flags.len_short  = len_reg < LW'(stdv_pkg::HEADER_BYTES);
        flags.base_mis   = mis_reg;
        flags.rsv_nz     = rdata_reg[63:32] != '0;
        flags.dir_bad    = dir_end_full > 37'(len_reg);
        flags.n_zero     = rdata_reg[31:0] == '0;
        flags.blob_mis   = rdata_reg[stdv_pkg::ALIGN_BITS-1:0] != '0;
        flags.boff_oob   = (rdata_reg < 64'(dir_end_reg)) || (rdata_reg > 64'(len_reg));
        flags.size_oob   = rdata_reg > 64'(rem_reg);
        flags.bad_size   = (rdata_reg < 64'(stdv_pkg::MIN_BLOB_BYTES))
                           || (rdata_reg[stdv_pkg::GRAIN_BITS-1:0] != '0);
        flags.bad_magic  = rdata_reg[31:0] != stdv_pkg::MAGIC_WORD;
        flags.last_entry = ((AW + 1)'(idx_reg) + (AW + 1)'(1)) == (AW + 1)'(n_reg);
    end

    always_comb begin
        unique case (cmd.off_sel)
            stdv_pkg::OFF_ZERO:  off_mux = '0;
            stdv_pkg::OFF_RSV:   off_mux = stdv_pkg::OFF_W'(4);
            stdv_pkg::OFF_ENTRY: off_mux = stdv_pkg::OFF_W'({idx_reg, 4'b1000});
            stdv_pkg::OFF_BLOB:  off_mux = boff_reg[stdv_pkg::OFF_W-1:0];
            default:             off_mux = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.push) begin
            m_status_reg <= cmd.code;
            m_off_reg    <= off_mux;
            m_count_reg  <= (cmd.code == stdv_pkg::STAT_OK) ?
                            stdv_pkg::COUNT_W'(n_reg) : '0;
        end
    end

    assign m_tdata = {7'b0, m_count_reg, m_off_reg, m_status_reg};

    `STDV_ASSERT(a_words_bound, aclk, aresetn, 1'b1, words_reg <= stdv_pkg::WCNT_W'(stdv_pkg::STORE_WORDS))
    `STDV_ASSERT(a_cap_full, aclk, aresetn, cap_reg, full)
    `STDV_ASSERT(a_len_bound, aclk, aresetn, 1'b1, (LW + 3)'(len_reg) <= (LW + 3)'({words_reg, 3'b000}))

endmodule

`default_nettype wire
